// ===== src/perceptron_trainer_macros.svh =====
// Assertion macros shared by the perceptron trainer RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PERCEPTRON_TRAINER_MACROS_SVH
`define PERCEPTRON_TRAINER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pt_pkg.sv =====
// Package for the perceptron trainer: widths, reset values, register codes,
// controller states and the control structs passed between lanes, merge and top.
// No dependencies.
package pt_pkg;

  localparam int FEATURES_DEF = 8;
  localparam int NUM_IN       = 8;
  localparam int X_W          = 16;
  localparam int W_W          = 32;
  localparam int LR_W         = 16;
  localparam int PROD_W       = X_W + W_W;
  localparam int DELTA_W      = 25;
  localparam int CNT16_W      = 16;
  localparam int AF_W         = 4;
  localparam int IDX_OUT_W    = 4;

  localparam logic signed [X_W-1:0] BIAS_ONE = 16'sd256;
  localparam logic [LR_W-1:0]       LR_RESET = 16'd6554;
  localparam logic [CNT16_W-1:0]    SC_RESET = 16'd4;
  localparam logic [AF_W-1:0]       AF_RESET = 4'd8;

  localparam logic [1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [1:0] REG_SAMPLE_COUNT    = 2'd1;
  localparam logic [1:0] REG_ACTIVE_FEATURES = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_STATUS,
    ST_READ
  } state_t;

  typedef struct packed {
    logic start;
    logic apply;
    logic desired;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
    logic decision;
  } merge_res_t;

endpackage

// ===== src/pt_lane.sv =====
// One weight lane: holds a Q15.16 weight, forms its product with the lane input
// and the rounded learning step, and applies the saturated update.
// Depends on pt_pkg.
module pt_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pt_pkg::lane_ctrl_t              ctrl,
  input  logic                            used,
  input  logic signed [pt_pkg::X_W-1:0]   x,
  input  logic [pt_pkg::LR_W-1:0]         lr,
  output logic signed [pt_pkg::W_W-1:0]   weight,
  output logic signed [pt_pkg::PROD_W-1:0] prod
);

  localparam int STEP_W = pt_pkg::LR_W + 1 + pt_pkg::X_W;

  logic signed [pt_pkg::W_W-1:0]     weight_r;
  logic signed [pt_pkg::W_W-1:0]     weight_nxt;
  logic signed [pt_pkg::PROD_W-1:0]  prod_r;
  logic signed [pt_pkg::DELTA_W-1:0] delta_r;
  logic signed [pt_pkg::DELTA_W-1:0] delta_nxt;
  logic signed [STEP_W-1:0]          step;
  logic signed [pt_pkg::W_W:0]       wide;
  logic signed [pt_pkg::W_W:0]       w_ext;
  logic signed [pt_pkg::W_W:0]       d_ext;

  always_comb begin
    step      = $signed({1'b0, lr}) * x + STEP_W'(128);
    delta_nxt = step[STEP_W-1:8];
    w_ext     = {weight_r[pt_pkg::W_W-1], weight_r};
    d_ext     = {{(pt_pkg::W_W + 1 - pt_pkg::DELTA_W){delta_r[pt_pkg::DELTA_W-1]}}, delta_r};
    wide      = ctrl.desired ? (w_ext + d_ext) : (w_ext - d_ext);
    if (wide[pt_pkg::W_W] != wide[pt_pkg::W_W-1]) begin
      weight_nxt = wide[pt_pkg::W_W] ? {1'b1, {(pt_pkg::W_W-1){1'b0}}}
                                     : {1'b0, {(pt_pkg::W_W-1){1'b1}}};
    end else begin
      weight_nxt = wide[pt_pkg::W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else if (ctrl.apply && used) begin
      weight_r <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      prod_r  <= x * weight_r;
      delta_r <= delta_nxt;
    end
  end

  assign weight = weight_r;
  assign prod   = prod_r;

endmodule

// ===== src/pt_merge.sv =====
// Merging stage: sums the lane products in a registered adder tree, one level
// per cycle, and reports the sign decision. Depends on pt_pkg.
module pt_merge #(
  parameter int LANES = pt_pkg::FEATURES_DEF + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pt_pkg::PROD_W-1:0]  prod [LANES],
  output pt_pkg::merge_res_t                res
);

  localparam int LEVELS = $clog2(LANES);
  localparam int SUM_W  = pt_pkg::PROD_W + LEVELS;
  localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic signed [SUM_W-1:0] part_r   [LANES];
  logic signed [SUM_W-1:0] part_nxt [LANES];
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic                    last_level;

  assign last_level = (cnt_r == CNT_W'(LEVELS - 1));

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      part_nxt[i] = '0;
      if (2 * i < LANES) begin
        part_nxt[i] = part_r[2 * i];
      end
      if (2 * i + 1 < LANES) begin
        part_nxt[i] = part_nxt[i] + part_r[2 * i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < LANES; i++) begin
        part_r[i] <= SUM_W'(prod[i]);
      end
    end else if (busy_r) begin
      for (int i = 0; i < LANES; i++) begin
        part_r[i] <= part_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_level;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last_level) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign res.done     = done_r;
  assign res.decision = (part_r[0] > 0);

endmodule

// ===== src/perceptron_trainer.sv =====
// Perceptron trainer top level: configuration registers, feature lanes, merge
// tree, training control and the output register. Depends on pt_pkg, pt_lane,
// pt_merge and perceptron_trainer_macros.svh.
//
// The lane products are registered at the edge that accepts a sample. The
// status item of that sample then passes these steps in order: loading the merge
// tree, one step per level of the tree, the decision and weight update, and
// loading the output register, which waits while the result side stalls. On
// convergence the weight readout then gives one weight per cycle while the result
// side does not stall. The next sample is accepted only once the last item of the
// previous one sits in the output register, so samples do not overlap.
`include "perceptron_trainer_macros.svh"

module perceptron_trainer #(
  parameter int FEATURES = pt_pkg::FEATURES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_feature_0,
  input  logic signed [15:0] in_feature_1,
  input  logic signed [15:0] in_feature_2,
  input  logic signed [15:0] in_feature_3,
  input  logic signed [15:0] in_feature_4,
  input  logic signed [15:0] in_feature_5,
  input  logic signed [15:0] in_feature_6,
  input  logic signed [15:0] in_feature_7,
  input  logic        in_desired_class,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic        out_decision,
  output logic        out_weights_changed,
  output logic [15:0] out_correct_run_out,
  output logic [15:0] out_sample_position,
  output logic        out_converged,
  output logic [3:0]  out_weight_index,
  output logic signed [31:0] out_weight_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LANES = FEATURES + 1;
  localparam int IDX_W = $clog2(LANES);

  logic [pt_pkg::LR_W-1:0]    lr_r;
  logic [pt_pkg::CNT16_W-1:0] sc_r;
  logic [pt_pkg::AF_W-1:0]    af_r;

  pt_pkg::state_t state_r, state_nxt;

  logic signed [pt_pkg::X_W-1:0]    feat   [pt_pkg::NUM_IN];
  logic signed [pt_pkg::W_W-1:0]    lane_w [LANES];
  logic signed [pt_pkg::PROD_W-1:0] lane_p [LANES];

  pt_pkg::lane_ctrl_t lane_ctrl;
  pt_pkg::merge_res_t merge_res;

  logic                       accept;
  logic                       out_free;
  logic                       merge_start;
  logic                       apply;
  logic                       load_status;
  logic                       load_read;
  logic                       wrong;
  logic                       last_read;
  logic                       desired_r;
  logic [pt_pkg::AF_W-1:0]    lanes_used;
  logic [pt_pkg::CNT16_W-1:0] count;
  logic [pt_pkg::CNT16_W-1:0] run_r;
  logic [pt_pkg::CNT16_W-1:0] run_new;
  logic [pt_pkg::CNT16_W-1:0] next_r;
  logic [pt_pkg::CNT16_W:0]   pos_inc;
  logic                       conv_new;
  logic [IDX_W-1:0]           idx_r;

  logic                       st_decision_r;
  logic                       st_changed_r;
  logic                       st_conv_r;
  logic [pt_pkg::CNT16_W-1:0] st_run_r;
  logic [pt_pkg::CNT16_W-1:0] st_pos_r;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_kind_r;
  logic                       out_decision_r;
  logic                       out_changed_r;
  logic [pt_pkg::CNT16_W-1:0] out_run_r;
  logic [pt_pkg::CNT16_W-1:0] out_pos_r;
  logic                       out_conv_r;
  logic [pt_pkg::IDX_OUT_W-1:0] out_index_r;
  logic signed [pt_pkg::W_W-1:0] out_weight_r;
  logic                       out_last_r;

  assign feat[0] = in_feature_0;
  assign feat[1] = in_feature_1;
  assign feat[2] = in_feature_2;
  assign feat[3] = in_feature_3;
  assign feat[4] = in_feature_4;
  assign feat[5] = in_feature_5;
  assign feat[6] = in_feature_6;
  assign feat[7] = in_feature_7;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= pt_pkg::LR_RESET;
      sc_r <= pt_pkg::SC_RESET;
      af_r <= pt_pkg::AF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3:2] == pt_pkg::REG_LEARNING_RATE) begin
        lr_r <= pwdata[pt_pkg::LR_W-1:0];
      end
      if (paddr[3:2] == pt_pkg::REG_SAMPLE_COUNT) begin
        sc_r <= pwdata[pt_pkg::CNT16_W-1:0];
      end
      if (paddr[3:2] == pt_pkg::REG_ACTIVE_FEATURES) begin
        af_r <= pwdata[pt_pkg::AF_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pt_pkg::REG_LEARNING_RATE:   prdata = {16'd0, lr_r};
      pt_pkg::REG_SAMPLE_COUNT:    prdata = {16'd0, sc_r};
      pt_pkg::REG_ACTIVE_FEATURES: prdata = {28'd0, af_r};
      default:                     prdata = '0;
    endcase
  end

  assign lanes_used = (af_r > pt_pkg::AF_W'(FEATURES)) ? pt_pkg::AF_W'(FEATURES) : af_r;
  assign count      = (sc_r == '0) ? pt_pkg::CNT16_W'(1) : sc_r;

  // Lanes and merge tree.
  assign lane_ctrl.start   = accept;
  assign lane_ctrl.apply   = apply;
  assign lane_ctrl.desired = desired_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [pt_pkg::X_W-1:0] x;
    logic                          used;
    if (i == 0) begin : g_bias
      assign x    = pt_pkg::BIAS_ONE;
      assign used = 1'b1;
    end else if (i <= pt_pkg::NUM_IN) begin : g_feat
      assign used = (pt_pkg::AF_W'(i) <= lanes_used);
      assign x    = used ? feat[i-1] : '0;
    end else begin : g_none
      assign used = (pt_pkg::AF_W'(i) <= lanes_used);
      assign x    = '0;
    end
    pt_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .used   (used),
      .x      (x),
      .lr     (lr_r),
      .weight (lane_w[i]),
      .prod   (lane_p[i])
    );
  end

  pt_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (merge_start),
    .prod  (lane_p),
    .res   (merge_res)
  );

  // Training control.
  assign in_stall  = (state_r != pt_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign wrong     = (merge_res.decision != desired_r);
  assign last_read = (pt_pkg::AF_W'(idx_r) == lanes_used);
  assign run_new   = wrong ? '0 : run_r + pt_pkg::CNT16_W'(1);
  assign conv_new  = (run_new >= count);
  assign pos_inc   = {1'b0, next_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    merge_start = 1'b0;
    apply       = 1'b0;
    load_status = 1'b0;
    load_read   = 1'b0;
    unique case (state_r)
      pt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pt_pkg::ST_MUL;
        end
      end
      pt_pkg::ST_MUL: begin
        merge_start = 1'b1;
        state_nxt   = pt_pkg::ST_SUM;
      end
      pt_pkg::ST_SUM: begin
        if (merge_res.done) begin
          apply     = wrong;
          state_nxt = pt_pkg::ST_STATUS;
        end
      end
      pt_pkg::ST_STATUS: begin
        if (out_free) begin
          load_status = 1'b1;
          state_nxt   = st_conv_r ? pt_pkg::ST_READ : pt_pkg::ST_IDLE;
        end
      end
      pt_pkg::ST_READ: begin
        if (out_free) begin
          load_read = 1'b1;
          if (last_read) begin
            state_nxt = pt_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = pt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      next_r <= pt_pkg::CNT16_W'(1);
      idx_r  <= '0;
    end else begin
      if (merge_res.done && state_r == pt_pkg::ST_SUM) begin
        if (conv_new) begin
          run_r <= '0;
        end else begin
          run_r  <= run_new;
          next_r <= (pos_inc > {1'b0, count}) ? pt_pkg::CNT16_W'(1)
                                               : pos_inc[pt_pkg::CNT16_W-1:0];
        end
      end
      if (load_status) begin
        idx_r <= '0;
      end else if (load_read) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desired_r <= in_desired_class;
    end
    if (merge_res.done && state_r == pt_pkg::ST_SUM) begin
      st_decision_r <= merge_res.decision;
      st_changed_r  <= wrong;
      st_run_r      <= run_new;
      st_conv_r     <= conv_new;
      st_pos_r      <= conv_new ? next_r
                     : ((pos_inc > {1'b0, count}) ? pt_pkg::CNT16_W'(1)
                                                  : pos_inc[pt_pkg::CNT16_W-1:0]);
    end
  end

  // Output register.
  assign out_valid_nxt = (load_status || load_read) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_kind_r     <= 1'b0;
      out_decision_r <= st_decision_r;
      out_changed_r  <= st_changed_r;
      out_run_r      <= st_run_r;
      out_pos_r      <= st_pos_r;
      out_conv_r     <= st_conv_r;
      out_index_r    <= '0;
      out_weight_r   <= '0;
      out_last_r     <= !st_conv_r;
    end else if (load_read) begin
      out_kind_r     <= 1'b1;
      out_decision_r <= 1'b0;
      out_changed_r  <= 1'b0;
      out_run_r      <= '0;
      out_pos_r      <= '0;
      out_conv_r     <= 1'b0;
      out_index_r    <= pt_pkg::IDX_OUT_W'(idx_r);
      out_weight_r   <= lane_w[idx_r];
      out_last_r     <= last_read;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_decision        = out_decision_r;
  assign out_weights_changed = out_changed_r;
  assign out_correct_run_out = out_run_r;
  assign out_sample_position = out_pos_r;
  assign out_converged       = out_conv_r;
  assign out_weight_index    = out_index_r;
  assign out_weight_value    = out_weight_r;
  assign out_last            = out_last_r;

  `PT_ASSERT_NOW(a_merge_done_in_sum, merge_res.done, state_r == pt_pkg::ST_SUM, "merge done outside sum state")
  `PT_ASSERT_NEXT(a_accept_to_mul, accept, state_r == pt_pkg::ST_MUL, "accepted item did not start")
  `PT_ASSERT_NOW(a_readout_index, out_valid_r && out_kind_r, out_index_r <= lanes_used, "readout index beyond used lanes")
  `PT_ASSERT_NOW(a_status_last, out_valid_r && !out_kind_r, out_last_r == !out_conv_r, "status last flag disagrees with convergence")
  `PT_ASSERT_NOW(a_changed_clears_run, out_valid_r && !out_kind_r && out_changed_r, out_run_r == '0, "run not cleared after weight update")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for perceptron_trainer: it feeds training samples, writes the
// configuration registers between phases and predicts every status and weight readout item.
// Depends on pt_pkg and the perceptron_trainer RTL.
module testbench;

  localparam int LANES = pt_pkg::NUM_IN;
  localparam int QUIET_LIMIT = 2000;
  localparam longint WEIGHT_MAX = 64'sd2147483647;
  localparam longint WEIGHT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [LANES-1:0][15:0] feature;
    logic                   desired;
  } sample_t;

  typedef struct packed {
    logic        kind;
    logic        decision;
    logic        changed;
    logic [15:0] run;
    logic [15:0] position;
    logic        converged;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_feature_0 = '0;
  logic signed [15:0] in_feature_1 = '0;
  logic signed [15:0] in_feature_2 = '0;
  logic signed [15:0] in_feature_3 = '0;
  logic signed [15:0] in_feature_4 = '0;
  logic signed [15:0] in_feature_5 = '0;
  logic signed [15:0] in_feature_6 = '0;
  logic signed [15:0] in_feature_7 = '0;
  logic in_desired_class = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_result_kind;
  logic out_decision;
  logic out_weights_changed;
  logic [15:0] out_correct_run_out;
  logic [15:0] out_sample_position;
  logic out_converged;
  logic [3:0] out_weight_index;
  logic signed [31:0] out_weight_value;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  perceptron_trainer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_feature_0        (in_feature_0),
    .in_feature_1        (in_feature_1),
    .in_feature_2        (in_feature_2),
    .in_feature_3        (in_feature_3),
    .in_feature_4        (in_feature_4),
    .in_feature_5        (in_feature_5),
    .in_feature_6        (in_feature_6),
    .in_feature_7        (in_feature_7),
    .in_desired_class    (in_desired_class),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_decision        (out_decision),
    .out_weights_changed (out_weights_changed),
    .out_correct_run_out (out_correct_run_out),
    .out_sample_position (out_sample_position),
    .out_converged       (out_converged),
    .out_weight_index    (out_weight_index),
    .out_weight_value    (out_weight_value),
    .out_last            (out_last),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #4 clk = ~clk;

  sample_t pending_samples [$];
  result_t expected_results [$];
  int samples_queued = 0;
  int samples_issued = 0;
  int samples_taken = 0;
  int results_taken = 0;
  int results_paced = 0;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  logic idle_sender = 1'b0;
  logic idle_receiver = 1'b0;

  logic signed [31:0] weight_model [0:LANES];
  logic [15:0] run_model = '0;
  logic [15:0] position_model = 16'd1;
  logic [15:0] rate_cfg = pt_pkg::LR_RESET;
  logic [15:0] count_cfg = pt_pkg::SC_RESET;
  logic [3:0]  lanes_cfg = pt_pkg::AF_RESET;

  initial begin
    for (int i = 0; i <= LANES; i++) weight_model[i] = '0;
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic train_on_sample(input sample_t s);
    longint x [0:LANES];
    longint acc;
    longint step;
    longint updated;
    int lanes;
    int count;
    logic decide;
    logic wrong;
    logic conv;
    logic [15:0] run_after;
    result_t r;
    lanes = (lanes_cfg > LANES) ? LANES : int'(lanes_cfg);
    count = (count_cfg == 0) ? 1 : int'(count_cfg);
    x[0] = longint'(pt_pkg::BIAS_ONE);
    for (int i = 1; i <= LANES; i++)
      x[i] = (i <= lanes) ? longint'($signed(s.feature[i-1])) : 0;
    acc = 0;
    for (int i = 0; i <= lanes; i++) acc += x[i] * longint'(weight_model[i]);
    decide = acc > 0;
    wrong = decide != s.desired;
    if (wrong) begin
      run_model = '0;
      for (int i = 0; i <= lanes; i++) begin
        step = (longint'(rate_cfg) * x[i] + 128) >>> 8;
        updated = s.desired ? longint'(weight_model[i]) + step
                            : longint'(weight_model[i]) - step;
        if (updated > WEIGHT_MAX) updated = WEIGHT_MAX;
        if (updated < WEIGHT_MIN) updated = WEIGHT_MIN;
        weight_model[i] = updated[31:0];
      end
    end else begin
      run_model = run_model + 16'd1;
    end
    run_after = run_model;
    conv = run_model >= count;
    if (conv) begin
      run_model = '0;
    end else if (int'(position_model) + 1 > count) begin
      position_model = 16'd1;
    end else begin
      position_model = position_model + 16'd1;
    end
    r = '0;
    r.decision = decide;
    r.changed = wrong;
    r.run = run_after;
    r.position = position_model;
    r.converged = conv;
    r.last = !conv;
    expected_results.push_back(r);
    if (conv) begin
      for (int i = 0; i <= lanes; i++) begin
        r = '0;
        r.kind = 1'b1;
        r.index = 4'(i);
        r.value = weight_model[i];
        r.last = (i == lanes);
        expected_results.push_back(r);
      end
    end
  endtask

  always @(negedge clk) begin
    sample_t cur;
    logic raise;
    raise = 1'b0;
    if (rst_n && samples_issued == samples_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        cur = pending_samples.pop_front();
        in_feature_0 <= cur.feature[0];
        in_feature_1 <= cur.feature[1];
        in_feature_2 <= cur.feature[2];
        in_feature_3 <= cur.feature[3];
        in_feature_4 <= cur.feature[4];
        in_feature_5 <= cur.feature[5];
        in_feature_6 <= cur.feature[6];
        in_feature_7 <= cur.feature[7];
        in_desired_class <= cur.desired;
        samples_issued <= samples_issued + 1;
        send_gap <= idle_sender ? $urandom_range(0, 6) : 0;
        raise = 1'b1;
      end
      in_valid <= raise;
    end
  end

  always @(negedge clk) begin
    int hold;
    if (rst_n) begin
      hold = stall_left;
      if (results_taken != results_paced) hold = idle_receiver ? $urandom_range(0, 6) : 0;
      out_stall <= (hold != 0);
      stall_left <= (hold != 0) ? hold - 1 : 0;
      results_paced <= results_taken;
    end
  end

  always @(posedge clk) begin
    sample_t s;
    result_t want;
    logic progress;
    if (rst_n) begin
      progress = 1'b0;
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        results_taken <= results_taken + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual kind %0h index %0h value %0h",
                   $time, out_result_kind, out_weight_index, out_weight_value);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("decision", want.decision, out_decision);
          check_field("weights_changed", want.changed, out_weights_changed);
          check_field("correct_run_out", want.run, out_correct_run_out);
          check_field("sample_position", want.position, out_sample_position);
          check_field("converged", want.converged, out_converged);
          check_field("weight_index", want.index, out_weight_index);
          check_field("weight_value", want.value, out_weight_value);
          check_field("last", want.last, out_last);
        end
      end
      if (in_valid && !in_stall) begin
        progress = 1'b1;
        s.feature[0] = in_feature_0;
        s.feature[1] = in_feature_1;
        s.feature[2] = in_feature_2;
        s.feature[3] = in_feature_3;
        s.feature[4] = in_feature_4;
        s.feature[5] = in_feature_5;
        s.feature[6] = in_feature_6;
        s.feature[7] = in_feature_7;
        s.desired = in_desired_class;
        train_on_sample(s);
        samples_taken <= samples_taken + 1;
      end
      if (psel && penable && pready) progress = 1'b1;
      quiet_cycles <= progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [1:0] code, input logic [31:0] value);
    logic [31:0] mask;
    mask = (code == pt_pkg::REG_ACTIVE_FEATURES) ? 32'hF : 32'hFFFF;
    for (int k = 0; k < 2; k++) begin
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= (k == 0);
      paddr <= {code, 2'b00};
      pwdata <= value;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (k == 1) check_field("register readback", value & mask, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (code)
      pt_pkg::REG_LEARNING_RATE:   rate_cfg = value[15:0];
      pt_pkg::REG_SAMPLE_COUNT:    count_cfg = value[15:0];
      pt_pkg::REG_ACTIVE_FEATURES: lanes_cfg = value[3:0];
      default: ;
    endcase
  endtask

  task automatic queue_sample(input sample_t s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] random_feature();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3: begin
        v = 16'($urandom_range(0, 511));
        v = v - 16'd256;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Zero features leave only the bias term, so the decision follows the bias weight.
  task automatic queue_agreeing_samples(input int n);
    sample_t s;
    s.feature = '0;
    s.desired = weight_model[0] > 0;
    for (int i = 0; i < n; i++) queue_sample(s);
  endtask

  task automatic queue_noise(input int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      for (int f = 0; f < LANES; f++) s.feature[f] = random_feature();
      s.desired = 1'($urandom_range(0, 1));
      queue_sample(s);
    end
  endtask

  // Labels come from a hidden weight vector, so each set is linearly separable.
  task automatic queue_training_set(input int set_size, input int epochs, input int lanes);
    sample_t set_items [$];
    sample_t s;
    longint hidden [0:LANES];
    longint score;
    for (int i = 0; i <= LANES; i++) hidden[i] = longint'($urandom_range(0, 254)) - 127;
    for (int n = 0; n < set_size; n++) begin
      for (int f = 0; f < LANES; f++) s.feature[f] = random_feature();
      score = hidden[0] * 256;
      for (int f = 0; f < lanes; f++) score += hidden[f+1] * longint'($signed(s.feature[f]));
      s.desired = score > 0;
      set_items.push_back(s);
    end
    for (int e = 0; e < epochs; e++) begin
      foreach (set_items[n]) queue_sample(set_items[n]);
      if ($urandom_range(0, 7) == 0) queue_noise(1);
    end
  endtask

  initial begin
    sample_t s;
    int rate_plan [8];
    int count_plan [8];
    int lanes_plan [8];
    int lanes;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    s.feature = '0;
    s.desired = 1'b0;
    queue_sample(s);
    s.desired = 1'b1;
    queue_sample(s);
    s.feature = {LANES{16'h7FFF}};
    s.desired = 1'b0;
    queue_sample(s);
    s.feature = {LANES{16'h8000}};
    s.desired = 1'b1;
    queue_sample(s);
    s.feature = {LANES{16'h5555}};
    queue_sample(s);
    s.feature = {LANES{16'hAAAA}};
    s.desired = 1'b0;
    queue_sample(s);
    s.feature = {{4{16'h8000}}, {4{16'h7FFF}}};
    s.desired = 1'b1;
    queue_sample(s);
    wait_drained();
    queue_agreeing_samples(4);
    wait_drained();

    idle_sender = 1'b1;
    idle_receiver = 1'b1;
    write_register(pt_pkg::REG_SAMPLE_COUNT, 0);
    write_register(pt_pkg::REG_ACTIVE_FEATURES, 0);
    queue_agreeing_samples(2);
    queue_noise(1);
    wait_drained();
    write_register(pt_pkg::REG_ACTIVE_FEATURES, 12);
    queue_noise(1);
    wait_drained();
    queue_agreeing_samples(1);
    wait_drained();

    // A lowered sample count below the current run converges on the next correct item.
    write_register(pt_pkg::REG_ACTIVE_FEATURES, LANES);
    write_register(pt_pkg::REG_SAMPLE_COUNT, 65535);
    queue_agreeing_samples(3);
    wait_drained();
    write_register(pt_pkg::REG_SAMPLE_COUNT, 2);
    queue_agreeing_samples(1);
    wait_drained();

    rate_plan = '{65535, 0, 0, 6554, 1, 65535, 0, 0};
    count_plan = '{3, 1, 5, 65535, 2, 8, 4, 6};
    lanes_plan = '{8, 1, 0, 8, 3, 8, 15, 0};
    rate_plan[2] = $urandom_range(1, 65534);
    rate_plan[6] = $urandom_range(1, 65534);
    rate_plan[7] = $urandom_range(1, 65534);
    lanes_plan[2] = $urandom_range(2, 7);
    for (int phase = 0; phase < 8; phase++) begin
      idle_sender = (phase % 3) != 0;
      idle_receiver = (phase % 3) != 1;
      write_register(pt_pkg::REG_LEARNING_RATE, rate_plan[phase]);
      write_register(pt_pkg::REG_SAMPLE_COUNT, count_plan[phase]);
      write_register(pt_pkg::REG_ACTIVE_FEATURES, lanes_plan[phase]);
      lanes = (lanes_plan[phase] > LANES) ? LANES : lanes_plan[phase];
      if (count_plan[phase] > LANES) queue_noise(12);
      else queue_training_set(count_plan[phase], 4, lanes);
      wait_drained();
    end

    repeat (40) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
